/* rtl/core/lcg48_with_jump_ahead_macros.svh */
// Assertion macros used by the sequencer module.
`ifndef LCG48_WITH_JUMP_AHEAD_MACROS_SVH
`define LCG48_WITH_JUMP_AHEAD_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define LCG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define LCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lcg48_pkg.sv */
package lcg48_pkg;

  localparam int unsigned StateBits = 48;
  localparam int unsigned CountBits = 64;
  localparam int unsigned IncBits   = 16;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 48;

  // The shared unit multiplies by one 16-bit slice of its second operand per enabled cycle.
  localparam int unsigned ChunkBits = 16;
  localparam int unsigned MacParts  = StateBits / ChunkBits;
  localparam int unsigned PartBits  = 2;
  localparam logic [PartBits-1:0] MacLast = PartBits'(MacParts - 1);

  localparam logic [StateBits-1:0] MultReset = 48'h0005_DEEC_E66D;
  localparam logic [IncBits-1:0]   IncReset  = 16'h000B;
  localparam logic [StateBits-1:0] SeedReset = 48'h1234_ABCD_330E;

  typedef enum logic [1:0] {
    FuncRestart = 2'd0,
    FuncStep    = 2'd1,
    FuncJumpRel = 2'd2,
    FuncJumpAbs = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CfgMult   = 2'd0,
    CfgInc    = 2'd1,
    CfgSeed   = 2'd2,
    CfgSeeded = 2'd3
  } cfg_idx_e;

  // Operations of the shared multiply-add unit.
  typedef enum logic [2:0] {
    OpPw   = 3'd0,  // pw   = pw * base
    OpSum  = 3'd1,  // sum  = sum * h + f
    OpBase = 3'd2,  // base = base * base
    OpF    = 3'd3,  // f    = f * (h + 1)
    OpH    = 3'd4,  // h    = h * h
    OpFin  = 3'd5,  // r    = r * pw + sum
    OpStep = 3'd6   // r    = a * r + c
  } mac_op_e;

  // Request from the sequencer to the datapath.
  typedef struct packed {
    logic                start;
    logic                mac_en;
    mac_op_e             op;
    logic [PartBits-1:0] part;
  } dp_ctrl_t;

endpackage

/* rtl/core/lcg48_if.sv */
interface lcg48_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [lcg48_pkg::CountBits-1:0] jump_count;
  modport source (output valid, func, jump_count, input ready);
  modport sink (input valid, func, jump_count, output ready);
endinterface

interface lcg48_out_if;
  logic        valid;
  logic        ready;
  logic [lcg48_pkg::StateBits-1:0] state_value;
  logic [30:0] high31;
  logic signed [31:0] signed32;
  logic        not_seeded;
  modport source (output valid, state_value, high31, signed32, not_seeded, input ready);
  modport sink (input valid, state_value, high31, signed32, not_seeded, output ready);
endinterface

interface lcg48_cfg_if;
  logic        valid;
  logic        ready;
  logic [lcg48_pkg::CfgIdxBits-1:0]  index;
  logic [lcg48_pkg::CfgDataBits-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/lcg48_dp.sv */
// Datapath: jump registers and one shared multiply-add unit that handles
// one 16-bit slice of its second operand per cycle while mac_en is set.
module lcg48_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lcg48_pkg::dp_ctrl_t               ctrl_i,
  input  logic [lcg48_pkg::StateBits-1:0]   start_r_i,
  input  logic [lcg48_pkg::StateBits-1:0]   mult_i,
  input  logic [lcg48_pkg::IncBits-1:0]     inc_i,
  output logic [lcg48_pkg::StateBits-1:0]   r_o
);

  localparam int unsigned W = lcg48_pkg::StateBits;
  localparam int unsigned C = lcg48_pkg::ChunkBits;

  logic [W-1:0] r_q, pw_q, base_q, sum_q, f_q, h_q, acc_q;
  logic [W-1:0] op_a, op_b, op_c, b_shift, pp_sh, acc_d;
  logic [C-1:0] chunk;
  logic [W+C-1:0] pp;
  logic [5:0] shamt;
  logic last;

  // Operand selection for the shared unit.
  always_comb begin
    op_a = pw_q;
    op_b = base_q;
    op_c = '0;
    case (ctrl_i.op)
      lcg48_pkg::OpPw: begin
        op_a = pw_q; op_b = base_q;
      end
      lcg48_pkg::OpSum: begin
        op_a = sum_q; op_b = h_q; op_c = f_q;
      end
      lcg48_pkg::OpBase: begin
        op_a = base_q; op_b = base_q;
      end
      lcg48_pkg::OpF: begin
        op_a = f_q; op_b = h_q + W'(1);
      end
      lcg48_pkg::OpH: begin
        op_a = h_q; op_b = h_q;
      end
      lcg48_pkg::OpFin: begin
        op_a = r_q; op_b = pw_q; op_c = sum_q;
      end
      lcg48_pkg::OpStep: begin
        op_a = mult_i; op_b = r_q; op_c = W'(inc_i);
      end
      default: begin
        op_a = pw_q; op_b = base_q;
      end
    endcase
  end

  // One partial product per cycle; the addend enters with the first slice.
  // Only the low product bits matter modulo 2^W.
  assign shamt   = {ctrl_i.part, 4'b0000};
  assign b_shift = op_b >> shamt;
  assign chunk   = b_shift[C-1:0];
  assign pp      = {{C{1'b0}}, op_a} * {{W{1'b0}}, chunk};
  assign pp_sh   = pp[W-1:0] << shamt;
  assign acc_d   = ((ctrl_i.part == '0) ? op_c : acc_q) + pp_sh;
  assign last    = (ctrl_i.part == lcg48_pkg::MacLast);

  // State register update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
    end else if (ctrl_i.start) begin
      r_q <= start_r_i;
    end else if (ctrl_i.mac_en && last &&
                 (ctrl_i.op == lcg48_pkg::OpFin || ctrl_i.op == lcg48_pkg::OpStep)) begin
      r_q <= acc_d;
    end
  end

  // Jump registers and the running partial sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q   <= '0;
      base_q <= '0;
      sum_q  <= '0;
      f_q    <= '0;
      h_q    <= '0;
      acc_q  <= '0;
    end else if (ctrl_i.start) begin
      pw_q   <= W'(1);
      base_q <= mult_i;
      sum_q  <= '0;
      f_q    <= W'(inc_i);
      h_q    <= mult_i;
    end else if (ctrl_i.mac_en) begin
      acc_q <= acc_d;
      if (last) begin
        case (ctrl_i.op)
          lcg48_pkg::OpPw:   pw_q   <= acc_d;
          lcg48_pkg::OpSum:  sum_q  <= acc_d;
          lcg48_pkg::OpBase: base_q <= acc_d;
          lcg48_pkg::OpF:    f_q    <= acc_d;
          lcg48_pkg::OpH:    h_q    <= acc_d;
          default: ;
        endcase
      end
    end
  end

  assign r_o = r_q;

endmodule

/* rtl/core/lcg48_seq.sv */
// Sequencer: walks the bits of the jump count and drives the shared unit.
module lcg48_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [1:0]                        func_i,
  input  logic                              seeded_i,
  input  logic [lcg48_pkg::CountBits-1:0]   count_i,
  input  logic                              res_taken_i,
  output logic                              busy_o,
  output logic                              done_o,
  output lcg48_pkg::dp_ctrl_t               ctrl_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StStep = 5'b00010,
    StBit  = 5'b00100,
    StFin  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [lcg48_pkg::CountBits-1:0] k_q, k_d;
  lcg48_pkg::mac_op_e op_q, op_d;
  logic [lcg48_pkg::PartBits-1:0] part_q, part_d;
  logic last, adv;

  // Next-state logic; each count bit takes up to five unit passes, and each
  // pass handles one operand slice per cycle.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    op_d    = op_q;
    part_d  = part_q;
    last    = (part_q == lcg48_pkg::MacLast);
    adv     = 1'b0;
    ctrl_o  = '{start: 1'b0, mac_en: 1'b0, op: op_q, part: part_q};
    case (state_q)
      StIdle: begin
        if (start_i) begin
          if (!seeded_i) begin
            state_d = StDone;
          end else begin
            k_d    = count_i;
            op_d   = lcg48_pkg::OpPw;
            part_d = '0;
            if (func_i == lcg48_pkg::FuncStep) begin
              state_d = StStep;
            end else begin
              ctrl_o.start = 1'b1;
              if (func_i == lcg48_pkg::FuncRestart) begin
                state_d = StDone;
              end else begin
                state_d = StBit;
              end
            end
          end
        end
      end
      StStep: begin
        ctrl_o.mac_en = 1'b1;
        ctrl_o.op     = lcg48_pkg::OpStep;
        part_d = last ? '0 : part_q + 1'b1;
        if (last) begin
          state_d = StDone;
        end
      end
      StBit: begin
        if (k_q == '0) begin
          state_d = StFin;
        end else begin
          ctrl_o.mac_en = k_q[0] || (op_q != lcg48_pkg::OpPw && op_q != lcg48_pkg::OpSum);
          adv = !ctrl_o.mac_en || last;
          part_d = adv ? '0 : part_q + 1'b1;
          if (adv) begin
            case (op_q)
              lcg48_pkg::OpPw:   op_d = lcg48_pkg::OpSum;
              lcg48_pkg::OpSum:  op_d = lcg48_pkg::OpBase;
              lcg48_pkg::OpBase: op_d = lcg48_pkg::OpF;
              lcg48_pkg::OpF:    op_d = lcg48_pkg::OpH;
              default: begin
                op_d = lcg48_pkg::OpPw;
                k_d  = k_q >> 1;
              end
            endcase
          end
        end
      end
      StFin: begin
        ctrl_o.mac_en = 1'b1;
        ctrl_o.op = lcg48_pkg::OpFin;
        part_d = last ? '0 : part_q + 1'b1;
        if (last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (res_taken_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      k_q     <= '0;
      op_q    <= lcg48_pkg::OpPw;
      part_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      op_q    <= op_d;
      part_q  <= part_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StDone);

`include "lcg48_with_jump_ahead_macros.svh"

  `LCG_ASSERT_NEXT(a_fin_to_done, clk_i, rst_ni, state_q == StFin && part_q == lcg48_pkg::MacLast, state_q == StDone, "final pass must end in done")
  `LCG_ASSERT_IMPL(a_start_idle, clk_i, rst_ni, start_i, state_q == StIdle, "start while busy")
  `LCG_ASSERT_IMPL(a_ctrl_excl, clk_i, rst_ni, ctrl_o.start, !ctrl_o.mac_en, "conflicting datapath requests")
  `LCG_ASSERT_IMPL(a_part_range, clk_i, rst_ni, 1'b1, part_q <= lcg48_pkg::MacLast, "slice index out of range")

endmodule

/* rtl/core/lcg48_with_jump_ahead.sv */
// Channel | Dir | Contents
// in_req  | in  | func, jump_count
// out_req | out | state_value, high31, signed32, not_seeded
// cfg_req | in  | index, data (multiplier, increment, seed_value, seeded)
//
// Restart and refused requests offer the result in the cycle after acceptance.
// The shared multiply-add unit handles 16 operand bits a cycle; a single step
// runs one pass in StStep and then offers its result in StDone.
// A jump walks jump_count up to its top set bit: a set bit runs the pw and sum passes, every bit
// the base, f and h passes, and a final pass then applies the result to the state.
// Reset clears the state to zero and loads the register defaults.
// A new request is accepted only after the previous result has been taken.
module lcg48_with_jump_ahead (
  input  logic           clk_i,
  input  logic           rst_ni,
  lcg48_in_if.sink       in_req,
  lcg48_out_if.source    out_req,
  lcg48_cfg_if.sink      cfg_req
);

  logic [lcg48_pkg::StateBits-1:0] mult_q, seed_q, r;
  logic [lcg48_pkg::IncBits-1:0]   inc_q;
  logic                            seeded_q;
  logic                            start, busy, done, taken;
  lcg48_pkg::dp_ctrl_t             ctrl;

  // Configuration registers.
  assign cfg_req.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q   <= lcg48_pkg::MultReset;
      inc_q    <= lcg48_pkg::IncReset;
      seed_q   <= lcg48_pkg::SeedReset;
      seeded_q <= 1'b0;
    end else if (cfg_req.valid) begin
      case (lcg48_pkg::cfg_idx_e'(cfg_req.index))
        lcg48_pkg::CfgMult:   mult_q   <= cfg_req.data;
        lcg48_pkg::CfgInc:    inc_q    <= cfg_req.data[lcg48_pkg::IncBits-1:0];
        lcg48_pkg::CfgSeed:   seed_q   <= cfg_req.data;
        lcg48_pkg::CfgSeeded: seeded_q <= cfg_req.data[0];
        default: ;
      endcase
    end
  end

  assign in_req.ready = !busy;
  assign start = in_req.valid && !busy;
  assign taken = out_req.valid && out_req.ready;

  lcg48_seq u_seq (
    .clk_i, .rst_ni,
    .start_i     (start),
    .func_i      (in_req.func),
    .seeded_i    (seeded_q),
    .count_i     (in_req.jump_count),
    .res_taken_i (taken),
    .busy_o      (busy),
    .done_o      (done),
    .ctrl_o      (ctrl)
  );

  lcg48_dp u_dp (
    .clk_i, .rst_ni,
    .ctrl_i    (ctrl),
    .start_r_i ((in_req.func == lcg48_pkg::FuncJumpRel) ? r : seed_q),
    .mult_i    (mult_q),
    .inc_i     (inc_q),
    .r_o       (r)
  );

  // Result views of the state.
  assign out_req.valid       = done;
  assign out_req.state_value = r;
  assign out_req.high31      = r[lcg48_pkg::StateBits-1 -: 31];
  assign out_req.signed32    = r[lcg48_pkg::StateBits-1 -: 32];
  assign out_req.not_seeded  = !seeded_q;

endmodule

/* sim/lcg48_result_check.sv */
`timescale 1ns / 1ps

// Watches the configuration, request and result channels of the generator.
// It keeps its own copy of the registers and the state, works out each
// result on request acceptance, and compares the results in order.
module lcg48_result_check (
  input  logic  clk_i,
  input  logic  rst_ni,
  lcg48_in_if   in_mon,
  lcg48_out_if  out_mon,
  lcg48_cfg_if  cfg_mon,
  output int    fail_cnt_o,
  output int    pending_o
);

  typedef struct packed {
    logic [47:0] state_value;
    logic [30:0] high31;
    logic [31:0] signed32;
    logic        not_seeded;
  } draw_t;

  logic [63:0] mult_q;
  logic [63:0] inc_q;
  logic [63:0] seed_q;
  logic        seeded_q;
  logic [63:0] gen_state;
  draw_t       draw_queue[$];

  // Computes a^n and c*(1 + a + ... + a^(n-1)) in 64-bit wrapping arithmetic,
  // then applies them to the start state.
  function automatic logic [63:0] jump_ahead(input logic [63:0] r, input logic [63:0] n);
    logic [63:0] pw;
    logic [63:0] base;
    logic [63:0] sum;
    logic [63:0] f;
    logic [63:0] h;
    pw   = 64'd1;
    base = mult_q;
    sum  = 64'd0;
    f    = inc_q;
    h    = mult_q;
    for (int b = 0; b < 64; b++) begin
      if (n[b]) begin
        pw  = pw * base;
        sum = sum * h + f;
      end
      base = base * base;
      f    = f * (h + 64'd1);
      h    = h * h;
    end
    return (r * pw + sum) & 64'hFFFF_FFFF_FFFF;
  endfunction

  assign pending_o = draw_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    draw_t want;
    draw_t got;
    if (!rst_ni) begin
      mult_q     <= 64'(lcg48_pkg::MultReset);
      inc_q      <= 64'(lcg48_pkg::IncReset);
      seed_q     <= 64'(lcg48_pkg::SeedReset);
      seeded_q   <= 1'b0;
      gen_state  <= 64'd0;
      fail_cnt_o <= 0;
      draw_queue.delete();
    end else begin
      // Register writes.
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (lcg48_pkg::cfg_idx_e'(cfg_mon.index))
          lcg48_pkg::CfgMult:   mult_q   <= {16'd0, cfg_mon.data};
          lcg48_pkg::CfgInc:    inc_q    <= {48'd0, cfg_mon.data[15:0]};
          lcg48_pkg::CfgSeed:   seed_q   <= {16'd0, cfg_mon.data};
          lcg48_pkg::CfgSeeded: seeded_q <= cfg_mon.data[0];
          default: ;
        endcase
      end

      // Predict the draw for each accepted request.
      if (in_mon.valid && in_mon.ready) begin
        logic [63:0] nxt;
        nxt = gen_state;
        if (seeded_q) begin
          case (lcg48_pkg::func_e'(in_mon.func))
            lcg48_pkg::FuncRestart: nxt = seed_q;
            lcg48_pkg::FuncStep:    nxt = (mult_q * gen_state + inc_q) & 64'hFFFF_FFFF_FFFF;
            lcg48_pkg::FuncJumpRel: nxt = jump_ahead(gen_state, in_mon.jump_count);
            default:                nxt = jump_ahead(seed_q, in_mon.jump_count);
          endcase
        end
        gen_state        <= nxt;
        want.state_value = nxt[47:0];
        want.high31      = nxt[47:17];
        want.signed32    = nxt[47:16];
        want.not_seeded  = !seeded_q;
        draw_queue.push_back(want);
      end

      // Compare each accepted result with the oldest prediction.
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.state_value, out_mon.high31, out_mon.signed32, out_mon.not_seeded};
        if (draw_queue.size() == 0) begin
          if (fail_cnt_o < 10) $display("unexpected result: %p", got);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = draw_queue.pop_front();
          if (got !== want) begin
            if (fail_cnt_o < 10) begin
              $display("mismatch: state exp %h got %h, high31 exp %h got %h",
                       want.state_value, got.state_value, want.high31, got.high31);
              $display("          signed32 exp %h got %h, not_seeded exp %b got %b",
                       want.signed32, got.signed32, want.not_seeded, got.not_seeded);
            end
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

// Drives requests and register writes into the generator and decides the verdict.
module testbench;

  localparam int IdleLimit = 6000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt;
  int   pending;
  int   idle_cycles = 0;
  bit   tx_idle_on = 0;
  bit   rx_stall_on = 0;
  int   hold_len = 0;

  lcg48_in_if  in_ch ();
  lcg48_out_if out_ch ();
  lcg48_cfg_if cfg_ch ();

  lcg48_with_jump_ahead i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req  (in_ch),
    .out_req (out_ch),
    .cfg_req (cfg_ch)
  );

  lcg48_result_check i_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always #5 clk_i = ~clk_i;

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        out_ch.ready = 1'b0;
        hold_len--;
      end else if (rx_stall_on) begin
        out_ch.ready = ($urandom_range(99) >= 82);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("** lcg48_with_jump_ahead: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input lcg48_pkg::cfg_idx_e idx, input logic [47:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_request(input lcg48_pkg::func_e fn, input logic [63:0] n);
    while (tx_idle_on && $urandom_range(99) < 82) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      = 1'b1;
    in_ch.func       = fn;
    in_ch.jump_count = n;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Lowers valid and waits until every draw has come back.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  function automatic lcg48_pkg::func_e pick_func();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 10) return lcg48_pkg::FuncRestart;
    if (p < 50) return lcg48_pkg::FuncStep;
    if (p < 80) return lcg48_pkg::FuncJumpRel;
    return lcg48_pkg::FuncJumpAbs;
  endfunction

  // Mostly short jumps, some of random length, some of full width.
  function automatic logic [63:0] pick_count();
    logic [63:0] n;
    int unsigned p;
    n = {$urandom, $urandom};
    p = $urandom_range(99);
    if (p < 70) return 64'($urandom_range(40));
    if (p < 85) return n >> $urandom_range(63);
    return n;
  endfunction

  function automatic logic [47:0] pick_wide();
    int unsigned p;
    p = $urandom_range(9);
    if (p == 0) return 48'd0;
    if (p == 1) return '1;
    return 48'({$urandom, $urandom});
  endfunction

  task automatic run_phase(input bit tx_idle, input bit rx_stall, input int count);
    tx_idle_on  = tx_idle;
    rx_stall_on = rx_stall;
    write_reg(lcg48_pkg::CfgMult,
              ($urandom_range(3) == 0) ? pick_wide() : lcg48_pkg::MultReset);
    write_reg(lcg48_pkg::CfgInc,
              ($urandom_range(4) == 0) ? 48'(16'hFFFF) : 48'($urandom_range(65535)));
    write_reg(lcg48_pkg::CfgSeed, pick_wide());
    write_reg(lcg48_pkg::CfgSeeded, 48'($urandom_range(9) != 0));
    for (int i = 0; i < count; i++) send_request(pick_func(), pick_count());
    drain();
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.func       = lcg48_pkg::FuncRestart;
    in_ch.jump_count = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = lcg48_pkg::CfgMult;
    cfg_ch.data      = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Refused operations before the generator is seeded.
    send_request(lcg48_pkg::FuncStep, 64'd0);
    send_request(lcg48_pkg::FuncJumpAbs, 64'd5);
    drain();

    // Every operation with the default parameters, zero and extreme jumps.
    write_reg(lcg48_pkg::CfgSeeded, 48'd1);
    send_request(lcg48_pkg::FuncRestart, 64'd0);
    send_request(lcg48_pkg::FuncStep, '1);
    send_request(lcg48_pkg::FuncJumpRel, 64'd0);
    send_request(lcg48_pkg::FuncJumpAbs, 64'd0);
    send_request(lcg48_pkg::FuncJumpRel, 64'd1);
    send_request(lcg48_pkg::FuncJumpRel, '1);
    send_request(lcg48_pkg::FuncJumpAbs, 64'h8000_0000_0000_0000);
    send_request(lcg48_pkg::FuncJumpAbs, 64'h5555_5555_5555_5555);
    send_request(lcg48_pkg::FuncJumpRel, 64'hAAAA_AAAA_AAAA_AAAA);
    drain();

    // Zero increment and extreme registers.
    write_reg(lcg48_pkg::CfgInc, 48'd0);
    write_reg(lcg48_pkg::CfgMult, '1);
    write_reg(lcg48_pkg::CfgSeed, '1);
    send_request(lcg48_pkg::FuncRestart, 64'd0);
    send_request(lcg48_pkg::FuncStep, 64'd0);
    send_request(lcg48_pkg::FuncJumpRel, 64'd12345);
    send_request(lcg48_pkg::FuncJumpAbs, '1);
    drain();
    write_reg(lcg48_pkg::CfgInc, 48'hFFFF);
    write_reg(lcg48_pkg::CfgMult, 48'd0);
    write_reg(lcg48_pkg::CfgSeed, 48'd0);
    send_request(lcg48_pkg::FuncRestart, 64'd0);
    send_request(lcg48_pkg::FuncStep, 64'd0);
    send_request(lcg48_pkg::FuncJumpRel, 64'd3);
    send_request(lcg48_pkg::FuncJumpAbs, '1);
    drain();

    // Long hold-off on the result side while requests keep coming.
    write_reg(lcg48_pkg::CfgMult, lcg48_pkg::MultReset);
    hold_len = 500;
    for (int i = 0; i < 6; i++) send_request(lcg48_pkg::FuncStep, 64'd0);
    drain();

    run_phase(0, 0, 250);
    run_phase(1, 0, 250);
    run_phase(0, 1, 250);
    run_phase(1, 1, 250);
    run_phase(0, 0, 250);
    run_phase(1, 0, 240);
    run_phase(0, 1, 240);

    if (fail_cnt == 0) begin
      $display("** lcg48_with_jump_ahead: PASSED **");
    end else begin
      $display("** lcg48_with_jump_ahead: FAILED **");
    end
    $finish;
  end

endmodule

/* lcg48_with_jump_ahead.f */
+incdir+rtl/core
rtl/core/lcg48_pkg.sv
rtl/core/lcg48_if.sv
rtl/core/lcg48_dp.sv
rtl/core/lcg48_seq.sv
rtl/core/lcg48_with_jump_ahead.sv
sim/lcg48_result_check.sv
sim/testbench.sv
